@@ sv/rfrr_pkg.sv @@
package rfrr_pkg;

  localparam int unsigned NUM_ENTRIES = 64;
  localparam int unsigned IDX_W       = $clog2(NUM_ENTRIES);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned PORT_IDX_W  = 6;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_PAGING  = 2'd3
  } task_state_e;

  localparam logic [1:0] PRIO_RT = 2'd0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_DISPATCHED = 2'd0,
    STAT_NONE_READY = 2'd1,
    STAT_DENIED     = 2'd2,
    STAT_WRITTEN    = 2'd3
  } status_e;

  typedef struct packed {
    task_state_e state;
    logic [1:0]  prio;
    logic        exec;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{state: ST_BLOCKED, prio: 2'd0, exec: 1'b0};

endpackage

@@ sv/realtime_first_round_robin_scheduler.sv @@
// Task dispatcher with a 64-entry table (state, priority, execute bit) in one
// synchronous memory. Issue a transaction by raising start_i while busy_o is low.
// A write transaction updates one entry in the accept cycle and keeps busy_o low;
// its result strobes on done_o in the next cycle. A tick reads the table one entry
// a cycle through the single memory read port, so busy_o stays high through
// the scan and S_DECIDE on none ready or denied, and also through S_DISP on a
// dispatch, which does the second write-back there. done_o pulses in the first
// cycle with busy_o low again. Results appear on done_o for one cycle only and
// must be captured then: the receiver cannot stall the block. After reset the
// whole table reads as blocked with no clearing pass.
module realtime_first_round_robin_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           opcode_i,
  input  logic [rfrr_pkg::PORT_IDX_W-1:0] entry_index_i,
  input  logic [1:0]                     new_state_i,
  input  logic [1:0]                     new_priority_i,
  input  logic                           new_exec_allowed_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [rfrr_pkg::PORT_IDX_W-1:0] chosen_index_o,
  output logic [rfrr_pkg::PORT_IDX_W-1:0] running_index_o
);
  import rfrr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_DISP   = 4'b1000
  } fsm_e;

  fsm_e fsm_q, fsm_d;

  entry_t               mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_q;
  entry_t               rdata_q;
  logic                 rvalid_q;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     cnt_m1;
  logic [IDX_W-1:0]     scan_idx;
  entry_t               scan_ent;
  logic                 scan_ready;

  logic [IDX_W-1:0]     cur_q;
  entry_t               cur_ent_q;

  logic                 rt_found_q, aft_found_q, any_found_q;
  logic [IDX_W-1:0]     rt_idx_q, aft_idx_q, any_idx_q;
  entry_t               rt_ent_q, aft_ent_q, any_ent_q;

  logic                 pick_found;
  logic [IDX_W-1:0]     pick_idx;
  entry_t               pick_ent;
  logic [IDX_W-1:0]     pick_idx_q;
  entry_t               pick_ent_q;

  logic                 accept;
  logic                 accept_wr;
  logic                 accept_tick;
  logic                 wr_in_range;

  logic                 done_q;
  status_e              status_q;
  logic [IDX_W-1:0]     chosen_q;
  logic [IDX_W-1:0]     running_q;

  assign busy_o      = (fsm_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign accept_wr   = accept && (opcode_e'(opcode_i) == OP_WRITE);
  assign accept_tick = accept && (opcode_e'(opcode_i) == OP_TICK);
  assign wr_in_range = (32'(entry_index_i) < NUM_ENTRIES);

  assign rd_addr    = cnt_q[IDX_W-1:0];
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign scan_idx   = cnt_m1[IDX_W-1:0];
  assign scan_ent   = rvalid_q ? rdata_q : ENTRY_RESET;
  assign scan_ready = (scan_ent.state == ST_READY);

  // realtime first, then first ready after current, else wrap to lowest ready
  always_comb begin
    pick_found = 1'b1;
    pick_idx   = any_idx_q;
    pick_ent   = any_ent_q;
    if (rt_found_q) begin
      pick_idx = rt_idx_q;
      pick_ent = rt_ent_q;
    end else if (aft_found_q) begin
      pick_idx = aft_idx_q;
      pick_ent = aft_ent_q;
    end else if (!any_found_q) begin
      pick_found = 1'b0;
    end
  end

  always_comb begin
    fsm_d     = fsm_q;
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(entry_index_i);
    mem_wdata = '{state: task_state_e'(new_state_i), prio: new_priority_i,
                  exec: new_exec_allowed_i};
    unique case (fsm_q)
      S_IDLE: begin
        if (accept_wr && wr_in_range) begin
          mem_we = 1'b1;
        end
        if (accept_tick) begin
          fsm_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == CNT_W'(NUM_ENTRIES)) begin
          fsm_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        fsm_d = S_IDLE;
        if (pick_found && !pick_ent.exec) begin
          mem_we          = 1'b1;
          mem_waddr       = pick_idx;
          mem_wdata       = pick_ent;
          mem_wdata.state = ST_BLOCKED;
        end else if (pick_found) begin
          // old running entry back to ready, picked one written next cycle
          mem_we          = 1'b1;
          mem_waddr       = cur_q;
          mem_wdata       = cur_ent_q;
          mem_wdata.state = ST_READY;
          fsm_d           = S_DISP;
        end
      end
      S_DISP: begin
        mem_we          = 1'b1;
        mem_waddr       = pick_idx_q;
        mem_wdata       = pick_ent_q;
        mem_wdata.state = ST_RUNNING;
        fsm_d           = S_IDLE;
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      rt_found_q  <= 1'b0;
      aft_found_q <= 1'b0;
      any_found_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      fsm_q  <= fsm_d;
      done_q <= accept_wr || (fsm_q == S_DECIDE && fsm_d == S_IDLE) ||
                (fsm_q == S_DISP);
      if (accept_tick) begin
        cnt_q       <= '0;
        rt_found_q  <= 1'b0;
        aft_found_q <= 1'b0;
        any_found_q <= 1'b0;
      end
      if (fsm_q == S_SCAN) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q != '0) begin
          if (scan_ready && (scan_ent.prio == PRIO_RT) && !rt_found_q) begin
            rt_found_q <= 1'b1;
          end
          if (scan_ready && !any_found_q) begin
            any_found_q <= 1'b1;
          end
          if (scan_ready && (scan_idx > cur_q) && !aft_found_q) begin
            aft_found_q <= 1'b1;
          end
        end
      end
      if (fsm_q == S_DISP) begin
        cur_q <= pick_idx_q;
      end
    end
  end

  // payload side of the scan and result registers
  always_ff @(posedge clk_i) begin
    if (fsm_q == S_SCAN && cnt_q != '0) begin
      if (scan_ready && (scan_ent.prio == PRIO_RT) && !rt_found_q) begin
        rt_idx_q <= scan_idx;
        rt_ent_q <= scan_ent;
      end
      if (scan_ready && !any_found_q) begin
        any_idx_q <= scan_idx;
        any_ent_q <= scan_ent;
      end
      if (scan_ready && (scan_idx > cur_q) && !aft_found_q) begin
        aft_idx_q <= scan_idx;
        aft_ent_q <= scan_ent;
      end
      if (scan_idx == cur_q) begin
        cur_ent_q <= scan_ent;
      end
    end
    if (fsm_q == S_DECIDE) begin
      pick_idx_q <= pick_idx;
      pick_ent_q <= pick_ent;
      running_q  <= cur_q;
      if (!pick_found) begin
        status_q <= STAT_NONE_READY;
        chosen_q <= cur_q;
      end else begin
        status_q <= STAT_DENIED;
        chosen_q <= pick_idx;
      end
    end
    if (fsm_q == S_DISP) begin
      status_q  <= STAT_DISPATCHED;
      chosen_q  <= pick_idx_q;
      running_q <= pick_idx_q;
    end
    if (accept_wr) begin
      status_q  <= STAT_WRITTEN;
      chosen_q  <= IDX_W'(entry_index_i);
      running_q <= cur_q;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign chosen_index_o  = PORT_IDX_W'(chosen_q);
  assign running_index_o = PORT_IDX_W'(running_q);

endmodule
